// File: hw/rtl/htss_pkg.sv
// Package: shared constants, segment table and digit split for the humidity/temperature display.
package htss_pkg;

    localparam int DIGIT_COUNT   = 4;
    localparam int STORED_DIGITS = 4;
    localparam int SCAN_W        = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int SELECT_W      = 4;

    localparam int RAW_W      = 16;
    localparam int DIGIT_W    = 4;
    localparam int SEG_W      = 8;
    localparam int PERIOD_W   = 10;
    localparam int SECONDS_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_PERIOD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_AFTER = 1'b1;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 10'd500;
    localparam logic [SECONDS_W-1:0] ENABLE_RESET = 16'd8;

    localparam int TEMP_PROD_W = 31;
    localparam int TEMP_SCL_W  = 14;
    localparam int HUM_PROD_W  = 23;
    localparam int VALUE_W     = 8;
    localparam int QUOT_PROD_W = 27;

    localparam logic [TEMP_PROD_W-1:0] TEMP_GAIN   = 31'd17572;
    localparam logic [TEMP_PROD_W-1:0] TEMP_OFFSET = 31'd307036160;
    localparam logic [HUM_PROD_W-1:0]  HUM_GAIN    = 23'd125;
    localparam logic [HUM_PROD_W-1:0]  HUM_OFFSET  = 23'd393216;
    localparam logic [QUOT_PROD_W-1:0] RECIP_100   = 27'd5243;
    localparam logic [15:0]            RECIP_10    = 16'd205;

    localparam logic [SEG_W-1:0] DP_OFF = 8'h80;

    localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
        8'hbf, 8'h86, 8'hdb, 8'hcf, 8'he6, 8'hed, 8'hfd, 8'h87,
        8'hff, 8'hef, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80
    };

    typedef logic [DIGIT_W-1:0] t_digit;

    // tens digit (mod 10 for values below 200) in the upper nibble, units digit in the lower
    function automatic logic [2*DIGIT_W-1:0] split_digits(input logic [VALUE_W-1:0] value);
        logic [15:0]        prod;
        logic [4:0]         tens;
        logic [VALUE_W-1:0] tens_ext;
        logic [VALUE_W-1:0] units;
        prod     = 16'(value) * RECIP_10;
        tens     = prod[15:11];
        tens_ext = VALUE_W'(tens);
        units    = value - (tens_ext << 3) - (tens_ext << 1);
        if (tens >= 5'd10) begin
            tens = tens - 5'd10;
        end
        return {tens[DIGIT_W-1:0], units[DIGIT_W-1:0]};
    endfunction

endpackage

// File: hw/rtl/htss_in_if.sv
// Interface: input item channel (scan tick or raw measurement pair).
interface htss_in_if
    import htss_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [RAW_W-1:0] raw_temp;
    logic [RAW_W-1:0] raw_humid;

    modport source (output valid, output command, output raw_temp, output raw_humid,
                    input ready);
    modport sink   (input valid, input command, input raw_temp, input raw_humid,
                    output ready);
endinterface

// File: hw/rtl/htss_out_if.sv
// Interface: display result channel.
interface htss_out_if
    import htss_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [SELECT_W-1:0] digit_select_n;
    logic [SEG_W-1:0]    segments;
    logic                measure_request;
    logic                power_enable;

    modport source (output valid, output digit_select_n, output segments,
                    output measure_request, output power_enable, input ready);
    modport sink   (input valid, input digit_select_n, input segments,
                    input measure_request, input power_enable, output ready);
endinterface

// File: hw/rtl/humidity_temp_seven_segment_driver_top.sv
// Top level: sensor conversion pipeline and four-digit seven-segment scan driver.
//
// Usage:
//   i_item carries one transaction per cycle while ready is high: command 0 is a scan tick, command 1 a
//   raw temperature/humidity pair. o_result returns exactly one transaction per input.
//   A measurement is converted over four register stages (scale, divide by 100,
//   digit split) and then stored as four digits; its result repeats the last
//   digit select and segment pattern with measure_request low.
//   A scan tick lights the next digit, counts ticks, pulses measure_request every
//   flag_period_ticks ticks and counts a second; power_enable latches once the
//   second count equals enable_after_seconds.
//   An accepted transaction moves through stages s1 to s4 into the output register.
//   Throughput: one transaction per cycle while o_result is ready; every stage holds one transaction.
//   Stall: a stage moves only when the next one is free, so a held result blocks
//   only the stages behind it; bubbles still fill while o_result waits.
//   Reset (i_rst_n low, synchronous): pipeline emptied, digits zero, select 15,
//   segments 0x80, counters and latch cleared, configuration back to 500 and 8.
//   Configuration: i_cfg_we writes register i_cfg_index; write only while idle.
module humidity_temp_seven_segment_driver_top
    import htss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    htss_in_if.sink               i_item,
    htss_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [PERIOD_W-1:0]  r_period;
    logic [SECONDS_W-1:0] r_enable_after;

    logic                 r_s1_valid;
    logic                 r_s1_cmd;
    logic [RAW_W-1:0]     r_s1_raw_temp;
    logic [RAW_W-1:0]     r_s1_raw_humid;

    logic                 r_s2_valid;
    logic                 r_s2_cmd;
    logic [TEMP_SCL_W-1:0] r_s2_temp_scaled;
    logic [VALUE_W-1:0]   r_s2_humid;

    logic                 r_s3_valid;
    logic                 r_s3_cmd;
    logic [VALUE_W-1:0]   r_s3_temp;
    logic [VALUE_W-1:0]   r_s3_humid;

    logic                 r_s4_valid;
    logic                 r_s4_cmd;
    logic [2*DIGIT_W-1:0] r_s4_temp_digits;
    logic [2*DIGIT_W-1:0] r_s4_humid_digits;

    logic                 r_o_valid;
    t_digit               r_digits [STORED_DIGITS];
    logic [SCAN_W-1:0]    r_scan;
    logic [PERIOD_W-1:0]  r_tick;
    logic [SECONDS_W-1:0] r_second;
    logic                 r_enable_latch;
    logic [SELECT_W-1:0]  r_last_select;
    logic [SEG_W-1:0]     r_last_segments;
    logic                 r_request;

    logic                 out_free;
    logic                 s4_ready;
    logic                 s3_ready;
    logic                 s2_ready;
    logic                 s1_ready;
    logic                 in_fire;
    logic                 out_fire;

    logic [TEMP_PROD_W-1:0] temp_prod;
    logic [TEMP_PROD_W-1:0] temp_diff;
    logic [HUM_PROD_W-1:0]  humid_prod;
    logic [HUM_PROD_W-1:0]  humid_diff;
    logic [QUOT_PROD_W-1:0] quot_prod;

    logic [SELECT_W-1:0]  pos_ext;
    t_digit               scan_digit;
    logic [SELECT_W-1:0]  scan_select;
    logic [SCAN_W-1:0]    n_scan;
    logic [PERIOD_W-1:0]  tick_inc;
    logic [PERIOD_W-1:0]  n_tick;
    logic [SECONDS_W-1:0] n_second;
    logic                 n_request;
    logic [SELECT_W-1:0]  n_last_select;
    logic [SEG_W-1:0]     n_last_segments;

    // handshake chain
    assign out_free = !r_o_valid || o_result.ready;
    assign s4_ready = !r_s4_valid || out_free;
    assign s3_ready = !r_s3_valid || s4_ready;
    assign s2_ready = !r_s2_valid || s3_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign i_item.ready = s1_ready;
    assign in_fire  = i_item.valid && s1_ready;
    assign out_fire = r_s4_valid && out_free;

    assign o_result.valid           = r_o_valid;
    assign o_result.digit_select_n  = r_last_select;
    assign o_result.segments        = r_last_segments;
    assign o_result.measure_request = r_request;
    assign o_result.power_enable    = r_enable_latch;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= PERIOD_RESET;
            r_enable_after <= ENABLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FLAG_PERIOD:  r_period       <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_ENABLE_AFTER: r_enable_after <= i_cfg_wdata[SECONDS_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_ready) r_s1_valid <= i_item.valid;
            if (s2_ready) r_s2_valid <= r_s1_valid;
            if (s3_ready) r_s3_valid <= r_s2_valid;
            if (s4_ready) r_s4_valid <= r_s3_valid;
            if (out_free) r_o_valid  <= r_s4_valid;
        end
    end

    // scale raw words and form the divide-by-100 product
    always_comb begin
        temp_prod  = TEMP_PROD_W'(r_s1_raw_temp) * TEMP_GAIN;
        temp_diff  = temp_prod - TEMP_OFFSET;
        humid_prod = HUM_PROD_W'(r_s1_raw_humid) * HUM_GAIN;
        humid_diff = humid_prod - HUM_OFFSET;
        quot_prod  = QUOT_PROD_W'(r_s2_temp_scaled) * RECIP_100;
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd       <= i_item.command;
            r_s1_raw_temp  <= i_item.raw_temp;
            r_s1_raw_humid <= i_item.raw_humid;
        end
        if (s2_ready) begin
            r_s2_cmd         <= r_s1_cmd;
            r_s2_temp_scaled <= (temp_prod < TEMP_OFFSET) ? '0 : temp_diff[29:16];
            r_s2_humid       <= (humid_prod < HUM_OFFSET) ? '0
                                : VALUE_W'(humid_diff[HUM_PROD_W-1:16]);
        end
        if (s3_ready) begin
            r_s3_cmd   <= r_s2_cmd;
            r_s3_temp  <= quot_prod[QUOT_PROD_W-1:19];
            r_s3_humid <= r_s2_humid;
        end
        if (s4_ready) begin
            r_s4_cmd          <= r_s3_cmd;
            r_s4_temp_digits  <= split_digits(r_s3_temp);
            r_s4_humid_digits <= split_digits(r_s3_humid);
        end
    end

    // scan step
    always_comb begin
        pos_ext     = SELECT_W'(r_scan);
        scan_digit  = '0;
        scan_select = '1;
        for (int k = 0; k < STORED_DIGITS; k++) begin
            if (pos_ext == SELECT_W'(k)) begin
                scan_digit  = r_digits[k];
                scan_select = ~(SELECT_W'(1) << k);
            end
        end
        n_scan   = (r_scan == SCAN_W'(DIGIT_COUNT - 1)) ? '0 : r_scan + 1'b1;
        tick_inc = r_tick + 1'b1;

        n_tick          = r_tick;
        n_second        = r_second;
        n_request       = 1'b0;
        n_last_select   = r_last_select;
        n_last_segments = r_last_segments;
        if (!r_s4_cmd) begin
            n_last_select   = scan_select;
            n_last_segments = SEG_TABLE[scan_digit];
            n_tick          = tick_inc;
            if (tick_inc == r_period) begin
                n_request = 1'b1;
                n_second  = r_second + 1'b1;
                n_tick    = '0;
            end
        end
    end

    // display and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORED_DIGITS; k++) begin
                r_digits[k] <= '0;
            end
            r_scan          <= '0;
            r_tick          <= '0;
            r_second        <= '0;
            r_enable_latch  <= 1'b0;
            r_last_select   <= '1;
            r_last_segments <= DP_OFF;
            r_request       <= 1'b0;
        end else if (out_fire) begin
            if (r_s4_cmd) begin
                r_digits[0] <= r_s4_temp_digits[2*DIGIT_W-1:DIGIT_W];
                r_digits[1] <= r_s4_temp_digits[DIGIT_W-1:0];
                r_digits[2] <= r_s4_humid_digits[2*DIGIT_W-1:DIGIT_W];
                r_digits[3] <= r_s4_humid_digits[DIGIT_W-1:0];
            end else begin
                r_scan <= n_scan;
            end
            r_tick          <= n_tick;
            r_second        <= n_second;
            r_request       <= n_request;
            r_last_select   <= n_last_select;
            r_last_segments <= n_last_segments;
            if (n_second == r_enable_after) begin
                r_enable_latch <= 1'b1;
            end
        end
    end

    a_enable_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_enable_latch))
        else $error("power enable dropped without reset");

    a_request_clears_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_request |-> (r_tick == '0))
        else $error("measure request without tick counter restart");

    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_s1_valid)
        else $error("accepted transaction lost at input stage");

endmodule

// File: sim/tb_humidity_temp_seven_segment_driver_top.sv
// Testbench: ticks and readings into the seven-segment driver, frames checked by a predictor.
`timescale 1ns / 1ps

import htss_pkg::*;

typedef enum logic {CMD_TICK = 1'b0, CMD_MEASURE = 1'b1} t_command;

typedef struct packed {
    t_command         command;
    logic [RAW_W-1:0] raw_temp;
    logic [RAW_W-1:0] raw_humid;
} t_sensor_item;

typedef struct packed {
    logic [SELECT_W-1:0] select_n;
    logic [SEG_W-1:0]    segments;
    logic                request;
    logic                power;
} t_display_frame;

class display_scoreboard;
    logic [PERIOD_W-1:0]  period_ticks;
    logic [SECONDS_W-1:0] enable_at;
    logic [DIGIT_W-1:0]   digits [STORED_DIGITS];
    int unsigned          scan_pos;
    logic [PERIOD_W-1:0]  tick_count;
    logic [SECONDS_W-1:0] second_count;
    logic                 power_latch;
    logic [SELECT_W-1:0]  shown_select;
    logic [SEG_W-1:0]     shown_segments;
    t_display_frame       expected_frames [$];
    int                   mismatches;

    function new();
        period_ticks   = PERIOD_RESET;
        enable_at      = ENABLE_RESET;
        foreach (digits[i]) digits[i] = '0;
        scan_pos       = 0;
        tick_count     = '0;
        second_count   = '0;
        power_latch    = 1'b0;
        shown_select   = '1;
        shown_segments = DP_OFF;
        mismatches     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index,
                                 logic [CFG_DATA_W-1:0] value);
        if (index == CFG_FLAG_PERIOD) begin
            period_ticks = value[PERIOD_W-1:0];
        end else if (index == CFG_ENABLE_AFTER) begin
            enable_at = value[SECONDS_W-1:0];
        end
    endfunction

    function logic [6:0] glyph(logic [DIGIT_W-1:0] value);
        case (value)
            4'd0: return 7'h3f;
            4'd1: return 7'h06;
            4'd2: return 7'h5b;
            4'd3: return 7'h4f;
            4'd4: return 7'h66;
            4'd5: return 7'h6d;
            4'd6: return 7'h7d;
            4'd7: return 7'h07;
            4'd8: return 7'h7f;
            4'd9: return 7'h6f;
            default: return 7'h00;
        endcase
    endfunction

    // clamp readings below zero
    function int unsigned scaled_reading(longint unsigned product, longint unsigned offset,
                                         longint unsigned divisor);
        if (product < offset) return 0;
        return int'((product - offset) / divisor);
    endfunction

    function void note_item(t_sensor_item item);
        t_display_frame     frame;
        int unsigned        temp_c;
        int unsigned        humid_pct;
        int unsigned        pos;
        logic [DIGIT_W-1:0] lit;
        frame.request = 1'b0;
        if (item.command == CMD_MEASURE) begin
            temp_c    = scaled_reading(64'd17572 * item.raw_temp, 64'd307036160,
                                       64'd6553600);
            humid_pct = scaled_reading(64'd125 * item.raw_humid, 64'd393216, 64'd65536);
            digits[0] = DIGIT_W'((temp_c / 10) % 10);
            digits[1] = DIGIT_W'(temp_c % 10);
            digits[2] = DIGIT_W'((humid_pct / 10) % 10);
            digits[3] = DIGIT_W'(humid_pct % 10);
        end else begin
            pos = scan_pos % DIGIT_COUNT;
            lit = '0;
            if (pos < STORED_DIGITS) lit = digits[pos];
            shown_select   = (pos < SELECT_W) ? ~(SELECT_W'(1) << pos) : '1;
            shown_segments = {1'b1, glyph(lit)};
            scan_pos       = (pos + 1) % DIGIT_COUNT;
            tick_count     = tick_count + 1'b1;
            if (tick_count == period_ticks) begin
                frame.request = 1'b1;
                second_count  = second_count + 1'b1;
                tick_count    = '0;
            end
        end
        if (second_count == enable_at) power_latch = 1'b1;
        frame.select_n = shown_select;
        frame.segments = shown_segments;
        frame.power    = power_latch;
        expected_frames.push_back(frame);
    endfunction

    function int pending();
        return expected_frames.size();
    endfunction

    task flag_mismatch(string what);
        mismatches++;
        $display("mismatch %0d at %0t: %s", mismatches, $time, what);
    endtask

    task check_result(t_display_frame got);
        t_display_frame want;
        if (expected_frames.size() == 0) begin
            flag_mismatch($sformatf("unexpected transaction select_n=%h segments=%h",
                                    got.select_n, got.segments));
            return;
        end
        want = expected_frames.pop_front();
        if (got.select_n !== want.select_n)
            flag_mismatch($sformatf("digit_select_n got %h want %h",
                                    got.select_n, want.select_n));
        if (got.segments !== want.segments)
            flag_mismatch($sformatf("segments got %h want %h",
                                    got.segments, want.segments));
        if (got.request !== want.request)
            flag_mismatch($sformatf("measure_request got %b want %b",
                                    got.request, want.request));
        if (got.power !== want.power)
            flag_mismatch($sformatf("power_enable got %b want %b",
                                    got.power, want.power));
    endtask
endclass

module tb_humidity_temp_seven_segment_driver_top;
    localparam int               CLK_HALF       = 6;
    localparam int               CYCLE_LIMIT    = 400000;
    localparam int               RANDOM_PHASES  = 8;
    localparam int               PHASE_ITEMS    = 20;
    localparam logic [RAW_W-1:0] TEMP_ZERO_RAW  = 16'd17474;
    localparam logic [RAW_W-1:0] HUMID_ZERO_RAW = 16'd3146;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    int                    tx_gap_pct   = 0;
    int                    rx_stall_pct = 0;
    int                    long_hold    = 0;
    int                    cycle_count  = 0;
    display_scoreboard     ledger;

    htss_in_if  item_ch ();
    htss_out_if result_ch ();

    humidity_temp_seven_segment_driver_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_sensor_item   taken;
        t_display_frame seen;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                taken.command   = t_command'(item_ch.command);
                taken.raw_temp  = item_ch.raw_temp;
                taken.raw_humid = item_ch.raw_humid;
                ledger.note_item(taken);
            end
            if (result_ch.valid && result_ch.ready) begin
                seen.select_n = result_ch.digit_select_n;
                seen.segments = result_ch.segments;
                seen.request  = result_ch.measure_request;
                seen.power    = result_ch.power_enable;
                ledger.check_result(seen);
            end
        end
    end

    initial begin
        result_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold > 0) begin
                result_ch.ready = 1'b0;
                repeat (long_hold) @(negedge i_clk);
                long_hold = 0;
            end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                result_ch.ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            result_ch.ready = 1'b1;
        end
    end

    function automatic t_sensor_item tick_item();
        t_sensor_item item;
        item.command   = CMD_TICK;
        item.raw_temp  = RAW_W'($urandom);
        item.raw_humid = RAW_W'($urandom);
        return item;
    endfunction

    function automatic t_sensor_item reading_item(logic [RAW_W-1:0] temp_raw,
                                                  logic [RAW_W-1:0] humid_raw);
        t_sensor_item item;
        item.command   = CMD_MEASURE;
        item.raw_temp  = temp_raw;
        item.raw_humid = humid_raw;
        return item;
    endfunction

    function automatic logic [RAW_W-1:0] random_raw(logic [RAW_W-1:0] zero_point);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? '1 : '0;
            1: return zero_point - RAW_W'($urandom_range(0, 64)) + 16'd32;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    task automatic drive_item(input t_sensor_item item);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            item_ch.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        item_ch.valid     = 1'b1;
        item_ch.command   = item.command;
        item_ch.raw_temp  = item.raw_temp;
        item_ch.raw_humid = item.raw_humid;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                drive_item(reading_item(random_raw(TEMP_ZERO_RAW), random_raw(HUMID_ZERO_RAW)));
            end else begin
                drive_item(tick_item());
            end
        end
    endtask

    task automatic wait_drained();
        item_ch.valid = 1'b0;
        while (ledger.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = value;
        ledger.write_register(index, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] period_pick;
        logic [CFG_DATA_W-1:0] enable_pick;
        ledger            = new();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_wdata       = '0;
        item_ch.valid     = 1'b0;
        item_ch.command   = CMD_TICK;
        item_ch.raw_temp  = '0;
        item_ch.raw_humid = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_register(CFG_FLAG_PERIOD, 16'd1);
        write_register(CFG_ENABLE_AFTER, 16'hffff);
        drive_item(reading_item('0, '0));
        drive_item(tick_item());
        drive_item(reading_item('1, '1));
        repeat (4) drive_item(tick_item());
        drive_item(reading_item(TEMP_ZERO_RAW - 1'b1, HUMID_ZERO_RAW - 1'b1));
        drive_item(tick_item());
        drive_item(reading_item(TEMP_ZERO_RAW, HUMID_ZERO_RAW));
        repeat (4) drive_item(tick_item());
        drive_item(reading_item(16'd26000, 16'd40000));
        repeat (5) drive_item(tick_item());
        wait_drained();

        // hold the result side long enough to back up the pipeline
        write_register(CFG_FLAG_PERIOD, 16'd1023);
        write_register(CFG_ENABLE_AFTER, 16'd0);
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        long_hold    = 90;
        repeat (40) drive_item(tick_item());
        wait_drained();

        // drop the period below the running count so the pulse waits for the wrap
        write_register(CFG_FLAG_PERIOD, 16'd0);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        repeat (1000) drive_item(tick_item());
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                period_pick = 16'd1023;
            end else if (phase == 3) begin
                period_pick = CFG_DATA_W'($urandom_range(1, 4));
            end else if ($urandom_range(0, 3) == 0) begin
                period_pick = CFG_DATA_W'($urandom_range(1, 1023));
            end else begin
                period_pick = CFG_DATA_W'($urandom_range(1, 12));
            end
            if (phase == 3) begin
                enable_pick = ledger.second_count + CFG_DATA_W'($urandom_range(1, 4));
            end else begin
                enable_pick = CFG_DATA_W'($urandom);
            end
            write_register(CFG_FLAG_PERIOD, period_pick);
            write_register(CFG_ENABLE_AFTER, enable_pick);
            if (phase >= RANDOM_PHASES - 2) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = $urandom_range(0, 2) * 15;
                rx_stall_pct = $urandom_range(0, 2) * 15;
            end
            send_random(PHASE_ITEMS / 2);
            if (phase == 1) wait_drained();
            send_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (ledger.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
